@@ rtl/histogram_equalization_macros.svh @@
// Assertion macros shared by the histogram equalization RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef HISTOGRAM_EQUALIZATION_MACROS_SVH
`define HISTOGRAM_EQUALIZATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/histeq_pkg.sv @@
// Shared widths, constants and controller/datapath command types for the
// histogram equalization block. No dependencies.
`default_nettype none

package histeq_pkg;

  localparam int PIX_W      = 8;         // input grey level width
  localparam int OUT_W      = 8;         // mapped grey level width
  localparam int CNT_W      = 21;        // frame size, pixel counter and bin width
  localparam int LEVELS_DEF = 256;       // default number of histogram bins
  localparam int unsigned MAX_FRAME = 1048576;

  localparam logic [CNT_W-1:0] FRAME_RST = CNT_W'(262144);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;      // write zero to the bin at the level counter
    logic cnt_rd;      // read the bin of the incoming pixel
    logic cnt_wr;      // write back the incremented bin
    logic bin_rd_lvl;  // read the bin at the level counter
    logic lvl_clr;     // level counter to zero
    logic lvl_inc;     // level counter up by one
    logic cum_clr;     // cumulative sum to zero
    logic cum_acc;     // add the bin just read to the cumulative sum
    logic mul_go;      // register the scaled dividend
    logic div_start;   // start the divider
    logic map_wr;      // write the rounded quotient into the map
    logic map_rd;      // look up the incoming pixel in the map
    logic pix_step;    // advance or wrap the pixel counter
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_pix;    // the next accepted pixel ends the pass
    logic lvl_last;    // level counter sits at the top level
    logic div_busy;    // divider still iterating
    logic slot_ok;     // map lookup path can take another pixel
  } status_t;

endpackage

`default_nettype wire

@@ rtl/histeq_in_if.sv @@
// Input pixel channel: valid/ready handshake carrying one grey level per beat.
// Depends on histeq_pkg for the pixel width.
`default_nettype none

interface histeq_in_if;
  import histeq_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

@@ rtl/histeq_out_if.sv @@
// Output pixel channel: valid/ready handshake carrying one mapped level per beat.
// Depends on histeq_pkg for the output width.
`default_nettype none

interface histeq_out_if;
  import histeq_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] out_pixel;

  modport source (output valid, output out_pixel, input ready);
  modport sink   (input valid, input out_pixel, output ready);
endinterface

`default_nettype wire

@@ rtl/histeq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module histeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/histeq_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, with a saturating
// quotient when the result does not fit in Q_W bits. No dependencies.
`default_nettype none

module histeq_div #(
  parameter int DVD_W = 30,
  parameter int DVS_W = 22,
  parameter int Q_W   = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic      [Q_W-1:0]   quot
);

  localparam int CMP_W = (DVD_W > DVS_W + Q_W) ? DVD_W : DVS_W + Q_W;
  localparam int SW    = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [CMP_W-1:0] rem;
  logic [CMP_W-1:0] dsr;
  logic [SW-1:0]    cnt;
  logic             ovf;
  logic             ge;

  assign ovf = CMP_W'(dividend) >= (CMP_W'(divisor) << Q_W);
  assign ge  = rem >= dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !ovf;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= CMP_W'(dividend);
      dsr  <= CMP_W'(divisor) << (Q_W - 1);
      cnt  <= SW'(Q_W - 1);
      quot <= ovf ? '1 : '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsr;
      end
      quot <= (quot << 1) | Q_W'(ge);
      dsr  <= dsr >> 1;
      cnt  <= cnt - SW'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/histeq_ctrl.sv @@
// Controller state machine: sequences the clearing sweep, the counting pass,
// the map build and the mapping pass. Depends on histeq_pkg and the macro header.
`default_nettype none
`include "histogram_equalization_macros.svh"

module histeq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire histeq_pkg::status_t status,
  output histeq_pkg::cmd_t        cmd
);
  import histeq_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_COUNT    = 4'd1;
  localparam logic [3:0] S_INC      = 4'd2;
  localparam logic [3:0] S_INC_LAST = 4'd3;
  localparam logic [3:0] S_BRD      = 4'd4;
  localparam logic [3:0] S_BACC     = 4'd5;
  localparam logic [3:0] S_BMUL     = 4'd6;
  localparam logic [3:0] S_BSTART   = 4'd7;
  localparam logic [3:0] S_BDIV     = 4'd8;
  localparam logic [3:0] S_BWR      = 4'd9;
  localparam logic [3:0] S_MAP      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.lvl_last) begin
          cmd.lvl_clr = 1'b1;
          state_next  = S_COUNT;
        end else begin
          cmd.lvl_inc = 1'b1;
        end
      end
      S_COUNT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cnt_rd   = 1'b1;
          cmd.pix_step = 1'b1;
          state_next   = status.last_pix ? S_INC_LAST : S_INC;
        end
      end
      S_INC: begin
        cmd.cnt_wr = 1'b1;
        state_next = S_COUNT;
      end
      S_INC_LAST: begin
        cmd.cnt_wr  = 1'b1;
        cmd.lvl_clr = 1'b1;
        cmd.cum_clr = 1'b1;
        state_next  = S_BRD;
      end
      S_BRD: begin
        cmd.bin_rd_lvl = 1'b1;
        state_next     = S_BACC;
      end
      S_BACC: begin
        cmd.cum_acc = 1'b1;
        cmd.clr_wr  = 1'b1;
        state_next  = S_BMUL;
      end
      S_BMUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_BSTART;
      end
      S_BSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_BDIV;
      end
      S_BDIV: begin
        if (!status.div_busy) begin
          state_next = S_BWR;
        end
      end
      S_BWR: begin
        cmd.map_wr = 1'b1;
        if (status.lvl_last) begin
          cmd.lvl_clr = 1'b1;
          state_next  = S_MAP;
        end else begin
          cmd.lvl_inc = 1'b1;
          state_next  = S_BRD;
        end
      end
      S_MAP: begin
        in_ready = status.slot_ok;
        if (in_valid && status.slot_ok) begin
          cmd.map_rd   = 1'b1;
          cmd.pix_step = 1'b1;
          if (status.last_pix) begin
            state_next = S_COUNT;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `HEQ_ASSERT_NEXT(a_count_goes_to_inc, state == S_COUNT && accept, state == S_INC || state == S_INC_LAST, "counted pixel did not lead to a bin update")
  `HEQ_ASSERT_NOW(a_bin_port_single, cmd.cnt_wr, !cmd.clr_wr && !cmd.cnt_rd, "bin RAM port used twice in one cycle")
  `HEQ_ASSERT_NOW(a_map_write_no_accept, cmd.map_wr, !cmd.map_rd && !in_ready, "pixel accepted while the map is being written")
  `HEQ_ASSERT_NEXT(a_build_ends_in_map, state == S_BWR && status.lvl_last, state == S_MAP, "map build did not end in the mapping pass")

endmodule

`default_nettype wire

@@ rtl/histeq_dpath.sv @@
// Datapath: frame size register, pixel and level counters, bin and map RAMs,
// dividend multiplier, divider and output register. Depends on histeq_pkg,
// histeq_ram, histeq_div and histeq_out_if.
`default_nettype none

module histeq_dpath #(
  parameter int LEVELS = histeq_pkg::LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [histeq_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic [histeq_pkg::PIX_W-1:0] pixel,
  input  wire histeq_pkg::cmd_t            cmd,
  output histeq_pkg::status_t              status,
  histeq_out_if.source                     pix_out
);
  import histeq_pkg::*;

  localparam int LW    = $clog2(LEVELS);
  localparam int DVD_W = CNT_W + LW + 1;
  localparam int DVS_W = CNT_W + 1;
  localparam int KMUL  = 2 * (LEVELS - 1);

  localparam logic [LW-1:0]    LVL_TOP = LW'(LEVELS - 1);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  logic [CNT_W-1:0] frame_pixels;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] pix_cnt;
  logic [LW-1:0]    lvl;
  logic [LW-1:0]    pix_idx;
  logic [LW-1:0]    idx_q;
  logic [CNT_W-1:0] cum;
  logic [DVD_W-1:0] dividend;
  logic [LW-1:0]    quot;
  logic [LW-1:0]    level_val;
  logic             div_busy;

  logic             bin_we;
  logic [LW-1:0]    bin_waddr;
  logic [CNT_W-1:0] bin_wdata;
  logic             bin_re;
  logic [LW-1:0]    bin_raddr;
  logic [CNT_W-1:0] bin_rdata;
  logic [OUT_W-1:0] map_rdata;

  logic             rd_pending;
  logic             move;
  logic             out_valid;
  logic [OUT_W-1:0] out_data;

  // Frame size register and its effective value.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= FRAME_RST;
    end else if (cfg_wr_en) begin
      frame_pixels <= cfg_wr_data;
    end
  end

  always_comb begin
    if (frame_pixels == '0) begin
      n_eff = ONE;
    end else if (32'(frame_pixels) > MAX_FRAME) begin
      n_eff = CNT_W'(MAX_FRAME);
    end else begin
      n_eff = frame_pixels;
    end
  end

  assign pix_idx = (32'(pixel) >= LEVELS) ? LVL_TOP : LW'(pixel);

  // Pixel counter across a pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt <= '0;
    end else if (cmd.pix_step) begin
      pix_cnt <= status.last_pix ? '0 : pix_cnt + ONE;
    end
  end

  // Level counter for the clearing sweep and the map build.
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= '0;
    end else if (cmd.lvl_clr) begin
      lvl <= '0;
    end else if (cmd.lvl_inc) begin
      lvl <= lvl + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) begin
      idx_q <= pix_idx;
    end
    if (cmd.cum_clr) begin
      cum <= '0;
    end else if (cmd.cum_acc) begin
      cum <= cum + bin_rdata;
    end
    if (cmd.mul_go) begin
      dividend <= DVD_W'(cum) * DVD_W'(KMUL) + DVD_W'(n_eff);
    end
  end

  // Histogram bins.
  assign bin_we    = cmd.cnt_wr || cmd.clr_wr;
  assign bin_waddr = cmd.cnt_wr ? idx_q : lvl;
  assign bin_wdata = cmd.cnt_wr ? bin_rdata + ONE : '0;
  assign bin_re    = cmd.cnt_rd || cmd.bin_rd_lvl;
  assign bin_raddr = cmd.cnt_rd ? pix_idx : lvl;

  histeq_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_bins (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .re    (bin_re),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  histeq_div #(.DVD_W(DVD_W), .DVS_W(DVS_W), .Q_W(LW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  ({n_eff, 1'b0}),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign level_val = (quot > LVL_TOP) ? LVL_TOP : quot;

  histeq_ram #(.WIDTH(OUT_W), .DEPTH(LEVELS)) u_map (
    .clk   (clk),
    .we    (cmd.map_wr),
    .waddr (lvl),
    .wdata (OUT_W'(level_val)),
    .re    (cmd.map_rd),
    .raddr (pix_idx),
    .rdata (map_rdata)
  );

  // Lookup result waits in the RAM read register until the output slot frees.
  assign move = rd_pending && (!out_valid || pix_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= cmd.map_rd || (rd_pending && !move);
      if (move) begin
        out_valid <= 1'b1;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= map_rdata;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.out_pixel = out_data;

  assign status.last_pix = ({1'b0, pix_cnt} + (CNT_W + 1)'(1)) >= {1'b0, n_eff};
  assign status.lvl_last = lvl == LVL_TOP;
  assign status.div_busy = div_busy;
  assign status.slot_ok  = !rd_pending || move;

endmodule

`default_nettype wire

@@ rtl/histogram_equalization.sv @@
// Top level of the histogram equalization block: joins the controller and the
// datapath. Depends on histeq_pkg, histeq_in_if, histeq_out_if, histeq_ctrl, histeq_dpath.
//
//   Channel   Direction  Beat / write                    Payload
//   pix_in    in         pix_in.valid && pix_in.ready    pixel[7:0]
//   pix_out   out        pix_out.valid && pix_out.ready  out_pixel[7:0]
//   cfg       in         cfg_wr_en                       cfg_wr_data[20:0] = frame_pixels
//
// After reset the bin RAM is swept to zero; no pixel is taken then.
// Each counting-pass pixel takes a read and a write-back of its bin before the next pixel is taken.
// The map build runs the bit-per-cycle divider once per level; the bins are zeroed
// on the way, so no later sweep is needed.
// The mapping pass takes one pixel per cycle; a stalled result holds the lookup
// path, and a single lookup may wait behind it before input stalls.
`default_nettype none

module histogram_equalization #(
  parameter int LEVELS = histeq_pkg::LEVELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [histeq_pkg::CNT_W-1:0] cfg_wr_data,
  histeq_in_if.sink                        pix_in,
  histeq_out_if.source                     pix_out
);
  import histeq_pkg::*;

  // Commands and status are the only link between controller and datapath.
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // The controller owns the input handshake; it decides from the pass state
  // and from whether the lookup path has room.
  histeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign pix_in.ready = in_ready;

  // The datapath holds all storage and drives the output channel directly.
  histeq_dpath #(.LEVELS(LEVELS)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pixel       (pix_in.pixel),
    .cmd         (cmd),
    .status      (status),
    .pix_out     (pix_out)
  );

endmodule

`default_nettype wire
